FILE: hdl/capture_record_deframer_defines.svh
// ---------------------------------------------------------------------------
// Capture record deframer assertion macros
// Shorthand for concurrent checks clocked on clk, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef CAPTURE_RECORD_DEFRAMER_DEFINES_SVH
`define CAPTURE_RECORD_DEFRAMER_DEFINES_SVH

// Check that is switched off while reset is high.
`define CRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also covers the reset cycles.
`define CRD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/crd_pkg.sv
// ---------------------------------------------------------------------------
// Capture record deframer package
// Frame constants, the frame event passed between stages and the record layout.
// ---------------------------------------------------------------------------
package crd_pkg;

  localparam logic [7:0]  SYNC_BYTE         = 8'h55;
  localparam logic [7:0]  TYPE_DATA         = 8'h10;
  localparam logic [7:0]  TYPE_STATUS       = 8'h01;
  localparam logic [15:0] MIN_DATA_LEN      = 16'd12;
  localparam logic [7:0]  CHANNEL_MASK      = 8'h3F;
  localparam logic [5:0]  CHANNEL_MAX       = 6'd39;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd512;
  localparam int          CAPTURE_BYTES     = 12;

  typedef enum logic {
    EV_ERROR,
    EV_RECORD
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [31:0] ts32;
    logic [7:0]  chan_raw;
    logic [7:0]  flags;
    logic [7:0]  rssi;
    logic [7:0]  pdu_hdr;
    logic [7:0]  pdu_len_byte;
    logic [15:0] total;
  } frame_event_t;

  // Last member first, so that the extended stamp lands in the lowest bits.
  typedef struct packed {
    logic [31:0]        error_total;
    logic [31:0]        record_index;
    logic [8:0]         pdu_length;
    logic [7:0]         pdu_header;
    logic [7:0]         flag_byte;
    logic signed [7:0]  rssi_dbm;
    logic               chan_phase;
    logic [5:0]         chan_num;
    logic [63:0]        stamp_delta;
    logic [63:0]        stamp_ext;
  } record_t;

  localparam int REC_BITS = $bits(record_t);

endpackage

FILE: hdl/crd_frame_parser.sv
// ---------------------------------------------------------------------------
// Capture frame parser
// Hunts for headers, tracks the payload, raises at most one event per frame end.
// ---------------------------------------------------------------------------
module crd_frame_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           max_payload,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  output logic                  ev_valid,
  output crd_pkg::frame_event_t ev,
  input  logic                  ev_take
);
  import crd_pkg::*;

  logic [2:0][7:0]                 win;
  logic [1:0]                      fill;
  logic                            in_payload;
  logic                            is_data;
  logic [15:0]                     pos;
  logic [15:0]                     total;
  logic [CAPTURE_BYTES-1:0][7:0]   cap;
  logic [CAPTURE_BYTES-1:0][7:0]   cap_next;
  logic [15:0]                     pos_next;
  logic [15:0]                     hdr_len;
  logic                            hdr_ok;
  logic                            pay_end;
  logic                            fire;
  logic                            accept;
  frame_event_t                    ev_next;

  assign in_ready = !ev_valid || ev_take;
  assign accept   = in_valid && in_ready;
  assign pos_next = pos + 16'd1;
  assign hdr_len  = {in_byte, win[2]};
  assign hdr_ok   = (win[0] == SYNC_BYTE) && (hdr_len <= max_payload) &&
                    ((win[1] == TYPE_DATA) || (win[1] == TYPE_STATUS));
  assign pay_end  = in_payload && (pos_next >= total);

  always_comb begin
    cap_next = cap;
    if (in_payload && (pos < MIN_DATA_LEN)) begin
      cap_next[pos[3:0]] = in_byte;
    end
    ev_next.ts32         = {cap_next[3], cap_next[2], cap_next[1], cap_next[0]};
    ev_next.chan_raw     = cap_next[4];
    ev_next.flags        = cap_next[5];
    ev_next.rssi         = cap_next[8];
    ev_next.pdu_hdr      = cap_next[10];
    ev_next.pdu_len_byte = cap_next[11];
    ev_next.total        = total;
    ev_next.kind         = EV_ERROR;
    fire                 = 1'b0;
    if (pay_end) begin
      if (!is_data) begin
        fire = 1'b1;
      end else if (total >= MIN_DATA_LEN) begin
        if (cap_next[5] != 8'h00) begin
          fire = 1'b1;
        end else if ((cap_next[4] & CHANNEL_MASK) <= {2'b00, CHANNEL_MAX}) begin
          fire         = 1'b1;
          ev_next.kind = EV_RECORD;
        end
      end
    end else if (!in_payload && (fill == 2'd3) && hdr_ok && (hdr_len == 16'd0) &&
                 (win[1] == TYPE_STATUS)) begin
      fire = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win        <= '0;
      fill       <= 2'd0;
      in_payload <= 1'b0;
      is_data    <= 1'b0;
      pos        <= 16'd0;
      total      <= 16'd0;
      ev_valid   <= 1'b0;
    end else begin
      ev_valid <= (ev_valid && !ev_take) || (accept && fire);
      if (accept) begin
        if (in_payload) begin
          pos <= pos_next;
          if (pay_end) begin
            in_payload <= 1'b0;
          end
        end else if (fill != 2'd3) begin
          win[fill] <= in_byte;
          fill      <= fill + 2'd1;
        end else if (!hdr_ok) begin
          win[0] <= win[1];
          win[1] <= win[2];
          win[2] <= in_byte;
        end else begin
          fill       <= 2'd0;
          win        <= '0;
          is_data    <= (win[1] == TYPE_DATA);
          total      <= hdr_len;
          pos        <= 16'd0;
          in_payload <= (hdr_len != 16'd0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cap <= cap_next;
      if (fire) begin
        ev <= ev_next;
      end
    end
  end

endmodule

FILE: hdl/crd_record_builder.sv
// ---------------------------------------------------------------------------
// Capture record builder
// Counts errors, extends timestamps and forms the output record in two stages.
// ---------------------------------------------------------------------------
module crd_record_builder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ev_valid,
  input  crd_pkg::frame_event_t         ev,
  output logic                          ev_take,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [crd_pkg::REC_BITS-1:0]  m_tdata
);
  import crd_pkg::*;

  logic [31:0] prev_stamp;
  logic [31:0] stamp_upper;
  logic [63:0] prev_ext;
  logic [31:0] rec_count;
  logic [31:0] fault_count;

  logic        rec_valid;
  record_t     rec_data;
  logic [63:0] rec_prev;
  logic        rec_first;
  record_t     out_data;
  record_t     out_next;

  logic        rec_take;
  logic        rec_free;
  logic        wrap;
  logic [31:0] upper_next;
  logic [15:0] pdu_room;
  logic [8:0]  pdu_want;
  logic [8:0]  pdu_len;

  assign rec_take = rec_valid && (!m_tvalid || m_tready);
  assign rec_free = !rec_valid || rec_take;
  assign ev_take  = ev_valid && ((ev.kind == EV_ERROR) || rec_free);

  assign wrap       = (rec_count != 32'd0) && (ev.ts32 < prev_stamp);
  assign upper_next = stamp_upper + {31'd0, wrap};
  assign pdu_room   = ev.total - 16'd10;
  assign pdu_want   = {1'b0, ev.pdu_len_byte} + 9'd2;
  assign pdu_len    = ({7'd0, pdu_want} > pdu_room) ? pdu_room[8:0] : pdu_want;

  always_comb begin
    out_next             = rec_data;
    out_next.stamp_delta = rec_first ? 64'd0 : (rec_data.stamp_ext - rec_prev);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_stamp  <= 32'd0;
      stamp_upper <= 32'd0;
      prev_ext    <= 64'd0;
      rec_count   <= 32'd0;
      fault_count <= 32'd0;
      rec_valid   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (rec_take) begin
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      rec_valid <= (rec_valid && !rec_take) || (ev_take && (ev.kind == EV_RECORD));
      if (ev_take) begin
        if (ev.kind == EV_ERROR) begin
          fault_count <= fault_count + 32'd1;
        end else begin
          stamp_upper <= upper_next;
          prev_stamp  <= ev.ts32;
          prev_ext    <= {upper_next, ev.ts32};
          rec_count   <= rec_count + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_take && (ev.kind == EV_RECORD)) begin
      rec_data.stamp_ext    <= {upper_next, ev.ts32};
      rec_data.stamp_delta  <= 64'd0;
      rec_data.chan_num     <= ev.chan_raw[5:0];
      rec_data.chan_phase   <= ev.chan_raw[7];
      rec_data.rssi_dbm     <= ev.rssi;
      rec_data.flag_byte    <= ev.flags;
      rec_data.pdu_header   <= ev.pdu_hdr;
      rec_data.pdu_length   <= pdu_len;
      rec_data.record_index <= rec_count;
      rec_data.error_total  <= fault_count;
      rec_prev              <= prev_ext;
      rec_first             <= (rec_count == 32'd0);
    end
    if (rec_take) begin
      out_data <= out_next;
    end
  end

  assign m_tdata = out_data;

endmodule

FILE: hdl/capture_record_deframer.sv
// After a frame's last byte, its result passes the event, record and output registers.
// One byte beat is taken every cycle unless an event waits untaken; the event, record
// and output registers (three deep) let input continue while a record waits at output.
// Reset is synchronous: the parser returns to hunting, all counters and the timestamp
// extension clear, and max_payload returns to 512.
// ---------------------------------------------------------------------------
// Capture record deframer
// Deframes a byte stream of capture frames into per-frame metadata records.
// ---------------------------------------------------------------------------
`include "capture_record_deframer_defines.svh"

module capture_record_deframer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [15:0]                   cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // rx_byte
  input  logic [7:0]                    s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // stamp_ext, stamp_delta, chan_num, chan_phase, rssi_dbm, flag_byte,
  // pdu_header, pdu_length, record_index, error_total
  output logic [crd_pkg::REC_BITS-1:0]  m_tdata
);
  import crd_pkg::*;

  logic         [15:0] max_payload;
  logic                ev_valid;
  frame_event_t        ev;
  logic                ev_take;
  record_t             out_view;

  assign cfg_ready = 1'b1;
  assign out_view  = m_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload <= cfg_data;
    end
  end

  crd_frame_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .max_payload (max_payload),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .ev_valid    (ev_valid),
    .ev          (ev),
    .ev_take     (ev_take)
  );

  crd_record_builder u_builder (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (ev_valid),
    .ev       (ev),
    .ev_take  (ev_take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `CRD_ASSERT(a_stall_needs_event, !s_tready |-> ev_valid, "input stalled with no pending event")
  `CRD_ASSERT(a_channel_range, m_tvalid |-> out_view.chan_num <= CHANNEL_MAX, "channel above limit")
  `CRD_ASSERT(a_first_interval, m_tvalid && out_view.record_index == 32'd0 |-> out_view.stamp_delta == 64'd0, "first record with nonzero interval")
  `CRD_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid && !ev_valid, "pipeline not empty after reset")

endmodule
